FILE: rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared constants and transaction types of the lattice coefficient
// compress and pack block.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int unsigned MODULUS         = 3329;
  localparam int unsigned COEFFS_PER_POLY = 256;
  localparam int unsigned MAX_SLOTS       = 4;

  localparam int unsigned COEFF_W   = 13;
  localparam int unsigned SLOT_W    = 2;
  localparam int unsigned VALUE_W   = 12;
  localparam int unsigned CWIDTH_W  = 4;
  localparam int unsigned TVAL_W    = 11;
  localparam int unsigned ADDR_W    = 11;
  localparam int unsigned INDEX_W   = 9;
  localparam int unsigned RES_W     = 7;
  localparam int unsigned RCNT_W    = 3;
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned SCALED_W  = 23;

  localparam int unsigned ADDR_SHIFT = $clog2(COEFFS_PER_POLY / 8);

  localparam logic [CWIDTH_W-1:0] CWIDTH_RESET = 4'd4;
  localparam logic [CWIDTH_W-1:0] CWIDTH_MIN   = 4'd1;
  localparam logic [CWIDTH_W-1:0] CWIDTH_MAX   = 4'd11;

  // floor(x / MODULUS) = (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2^23
  localparam int unsigned RECIP_SHIFT = 35;
  localparam logic [23:0] RECIP_M     = 24'd10321340;
  localparam logic [SCALED_W-1:0] HALF_Q = SCALED_W'(MODULUS / 2);

  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic        REG_CWIDTH = 1'b0;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic [SLOT_W-1:0]         vector_slot;
    logic                      last_coeff;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              last_byte;
  } out_item_t;

endpackage

FILE: rtl/lattice_coeff_compress_pack_top.sv
// ----------------------------------------------------------------------------
// lattice_coeff_compress_pack_top
// Reduces, compresses to d bits and packs signed coefficients into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Coefficients enter on the in_* channel (valid/stall), one transaction per
//   coefficient. Packed bytes leave on the out_* channel, one per transaction,
//   each with its address in the vector and a mark on the final byte of a
//   polynomial. The width d sits in the APB register at address 0; the user
//   must write it only while the block is idle, as the block does not enforce it.
//   A coefficient passes through the input register, the compression
//   register after the multiplier and the output buffer before its first
//   byte is offered on the output.
//   Throughput: one coefficient per cycle while the output is not stalled and
//   no more than one byte per coefficient is produced; the output port moves
//   one byte per cycle, so coefficients that complete two bytes slow the input.
//   A stall on the output holds the current byte; the two-entry output buffer
//   and the two pipeline registers fill, and then in_stall_o rises.
//   Reset sets d to 4 and clears the bit residue, its count, the byte index
//   and all valid flags; no clearing pass follows.
// ----------------------------------------------------------------------------
module lattice_coeff_compress_pack_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lcc_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lcc_pkg::out_item_t                  out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lcc_pkg::PADDR_W-1:0]         paddr,
  input  logic [lcc_pkg::PDATA_W-1:0]         pwdata,
  output logic [lcc_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  import lcc_pkg::*;

  logic [CWIDTH_W-1:0] cwidth_q;
  logic [CWIDTH_W-1:0] d_eff;

  logic     valid_a_q;
  in_item_t item_a_q;

  logic              valid_b_q;
  logic [TVAL_W-1:0] t_q;
  logic [SLOT_W-1:0] slot_b_q;
  logic              last_b_q;

  logic [RES_W-1:0]   res_q, res_d;
  logic [RCNT_W-1:0]  rcnt_q, rcnt_d;
  logic [INDEX_W-1:0] bidx_q, bidx_d;

  out_item_t buf_q [2];
  out_item_t buf_d [2];
  logic [1:0] cnt_q, cnt_d;

  logic in_accept, load_b, fire_b, b_free, pop;
  logic [1:0] cnt_rem;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CWIDTH) ? PDATA_W'(cwidth_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwidth_q <= CWIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CWIDTH)) begin
      cwidth_q <= pwdata[CWIDTH_W-1:0];
    end
  end

  always_comb begin
    if (cwidth_q < CWIDTH_MIN) begin
      d_eff = CWIDTH_MIN;
    end else if (cwidth_q > CWIDTH_MAX) begin
      d_eff = CWIDTH_MAX;
    end else begin
      d_eff = cwidth_q;
    end
  end

  // flow control
  assign pop       = (cnt_q != 2'd0) && !out_stall_i;
  assign cnt_rem   = cnt_q - {1'b0, pop};
  assign b_free    = !valid_b_q || fire_b;
  assign load_b    = valid_a_q && b_free;
  assign in_stall_o = valid_a_q && !load_b;
  assign in_accept = in_valid_i && !in_stall_o;

  // stage A: reduce and compress
  logic [COEFF_W-1:0]  raw, mag, mred;
  logic [VALUE_W-1:0]  u;
  logic [SCALED_W-1:0] scaled;
  logic [46:0]         prod;
  logic [VALUE_W-1:0]  quot, tmask;

  always_comb begin
    raw  = item_a_q.coeff;
    mag  = COEFF_W'(0) - raw;
    mred = (mag >= COEFF_W'(MODULUS)) ? mag - COEFF_W'(MODULUS) : mag;
    if (raw[COEFF_W-1]) begin
      u = (mred == '0) ? '0 : VALUE_W'(COEFF_W'(MODULUS) - mred);
    end else if (raw[VALUE_W-1:0] >= VALUE_W'(MODULUS)) begin
      u = raw[VALUE_W-1:0] - VALUE_W'(MODULUS);
    end else begin
      u = raw[VALUE_W-1:0];
    end
    scaled = (SCALED_W'(u) << d_eff) + HALF_Q;
    prod   = {24'b0, scaled} * {23'b0, RECIP_M};
    quot   = prod[46:RECIP_SHIFT];
    tmask  = (VALUE_W'(1) << d_eff) - VALUE_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (in_accept) begin
        valid_a_q <= 1'b1;
      end else if (load_b) begin
        valid_a_q <= 1'b0;
      end
      if (load_b) begin
        valid_b_q <= 1'b1;
      end else if (fire_b) begin
        valid_b_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_a_q <= in_data_i;
    end
    if (load_b) begin
      t_q      <= TVAL_W'(quot & tmask);
      slot_b_q <= item_a_q.vector_slot;
      last_b_q <= item_a_q.last_coeff;
    end
  end

  // stage B: pack into bytes
  logic [ACC_W-1:0]  acc;
  logic [4:0]        bits;
  logic [1:0]        nbytes;
  logic [SLOT_W-1:0] slot_sat;
  logic [5:0]        slot_d;
  logic [ADDR_W-1:0] base;
  out_item_t         r0, r1;

  always_comb begin
    acc    = (ACC_W'(t_q) << rcnt_q) | ACC_W'(res_q);
    bits   = 5'(rcnt_q) + 5'(d_eff);
    nbytes = bits[4] ? 2'd2 : (bits[3] ? 2'd1 : 2'd0);
    slot_sat = ({1'b0, slot_b_q} >= (SLOT_W+1)'(MAX_SLOTS)) ?
               SLOT_W'(MAX_SLOTS - 1) : slot_b_q;
    slot_d = 6'(slot_sat) * 6'(d_eff);
    base   = ADDR_W'(slot_d) << ADDR_SHIFT;
    r0.out_byte     = acc[7:0];
    r0.byte_address = base + ADDR_W'(bidx_q);
    r0.last_byte    = last_b_q && (nbytes == 2'd1);
    r1.out_byte     = acc[15:8];
    r1.byte_address = base + ADDR_W'(bidx_q + INDEX_W'(1));
    r1.last_byte    = last_b_q && (nbytes == 2'd2);
    fire_b = valid_b_q && ((3'(cnt_rem) + 3'(nbytes)) <= 3'd2);

    res_d  = res_q;
    rcnt_d = rcnt_q;
    bidx_d = bidx_q;
    if (fire_b) begin
      if (last_b_q) begin
        res_d  = '0;
        rcnt_d = '0;
        bidx_d = '0;
      end else begin
        case (nbytes)
          2'd2:    res_d = RES_W'(acc[17:16]);
          2'd1:    res_d = acc[14:8];
          default: res_d = acc[6:0];
        endcase
        rcnt_d = bits[2:0];
        bidx_d = bidx_q + INDEX_W'(nbytes);
      end
    end
  end

  // output buffer
  always_comb begin
    buf_d[0] = pop ? buf_q[1] : buf_q[0];
    buf_d[1] = buf_q[1];
    cnt_d    = cnt_rem;
    if (fire_b) begin
      if (cnt_rem == 2'd0) begin
        buf_d[0] = r0;
        buf_d[1] = r1;
      end else if (cnt_rem == 2'd1) begin
        buf_d[1] = r0;
      end
      cnt_d = cnt_rem + nbytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= '0;
      rcnt_q <= '0;
      bidx_q <= '0;
      cnt_q  <= '0;
    end else begin
      res_q  <= res_d;
      rcnt_q <= rcnt_d;
      bidx_q <= bidx_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q[0] <= buf_d[0];
    buf_q[1] <= buf_d[1];
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[0];

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer overfilled");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_b && last_b_q |=> (rcnt_q == '0) && (bidx_q == '0) && (res_q == '0))
    else $error("packing state not cleared after final coefficient");

  a_stall_holds_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> valid_a_q && $stable(item_a_q))
    else $error("input register lost a held transaction");

endmodule
